@@ rtl/core/bwm_pkg.sv @@
// shared types, sizes and codes for the breakpoint / watchpoint match table
// no dependencies; used by the interfaces, the top level and the testbench

package bwm_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int ADDR_W  = 32;
    localparam int DATA_W  = 32;

    localparam logic [1:0] REQ_CHECK = 2'd0;
    localparam logic [1:0] REQ_SET   = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    localparam logic [1:0] KIND_READ  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_EXEC  = 2'd2;

    localparam logic CFG_BREAK_EN = 1'b0;
    localparam logic CFG_WATCH_EN = 1'b1;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] data_value;
        logic [1:0]        access_kind;
        logic              want_read;
        logic              want_write;
        logic              want_execute;
        logic              compare_value;
        logic              is_watch;
    } t_req;

    typedef struct packed {
        logic break_hit;
        logic watch_hit;
        logic status;
    } t_rsp;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] value;
        logic [2:0]        kinds;
        logic              value_check;
        logic              watch;
    } t_slot;

    // trigger bit for an access kind; the unused code matches nothing
    function automatic logic [2:0] kind_mask(input logic [1:0] kind);
        logic [2:0] m;
        case (kind)
            KIND_READ:  m = 3'b001;
            KIND_WRITE: m = 3'b010;
            KIND_EXEC:  m = 3'b100;
            default:    m = 3'b000;
        endcase
        return m;
    endfunction

endpackage

@@ rtl/core/bwm_if.sv @@
// request and response channel interfaces with valid / ready handshake
// depends on bwm_pkg for the payload types

interface bwm_req_if;
    logic          valid;
    logic          ready;
    bwm_pkg::t_req payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface bwm_rsp_if;
    logic          valid;
    logic          ready;
    bwm_pkg::t_rsp payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/core/bwm_slot_ram.sv @@
// single port slot memory, one write or one read per cycle, registered read data
// generic; widths come from its parameters, no package needed

module bwm_slot_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic             i_re,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/breakpoint_watchpoint_matcher_top.sv @@
// top level of the breakpoint / watchpoint match table: sequencer, valid bits, response register
// depends on bwm_pkg, bwm_if and bwm_slot_ram

// Usage:
// i_req carries one transaction per request: an access check, a set of one entry,
// or a clear of the whole table. o_rsp returns exactly one transaction per request
// with break_hit, watch_hit and status. The two enables are written on the
// i_cfg_* port (index 0 break enable, index 1 watch enable), by the user only
// while the block is idle; the block itself does not enforce this. Checks and
// sets walk the slot memory one entry a cycle through its single read port:
// an issue step per slot, one compare step for the last slot, one drain step
// and the finish step, which registers the result. Clears and unused request
// codes go straight to the finish step once the transaction is accepted. One request
// is in flight at a time; i_req.ready is high again once the result has been
// placed in the output register, even if that result still waits to be taken.
// If o_rsp is stalled while another result is ready, the finish step waits.
// Reset clears the valid bits and enables at once; no memory sweep is needed.
// A set writes the slot back in the finish step, before the next scan can read it.

module breakpoint_watchpoint_matcher_top (
    input  logic           i_clk,
    input  logic           i_rst_n,
    bwm_req_if.sink        i_req,
    bwm_rsp_if.source      o_rsp,
    input  logic           i_cfg_we,
    input  logic           i_cfg_idx,
    input  logic           i_cfg_wdata
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]                  r_state, n_state;
    bwm_pkg::t_req               r_req;
    logic [bwm_pkg::ENTRIES-1:0] r_valid;
    logic                        r_break_en, r_watch_en;
    logic [bwm_pkg::CNT_W-1:0]   r_issue;
    logic                        r_cmp_vld;
    logic [bwm_pkg::IDX_W-1:0]   r_cmp_idx;
    logic                        r_found, r_free_found;
    logic [bwm_pkg::IDX_W-1:0]   r_hit_idx, r_free_idx;
    logic                        r_brk, r_wat;
    logic                        r_rsp_valid;
    bwm_pkg::t_rsp               r_rsp;

    logic                        req_acc, issue_left, finish;
    logic                        ram_we, ram_re;
    logic [bwm_pkg::IDX_W-1:0]   ram_addr, wr_idx;
    bwm_pkg::t_slot              ram_wdata, rd_slot;
    logic                        slot_match, slot_hit, set_ok;

    assign req_acc    = i_req.valid && i_req.ready;
    assign issue_left = (r_issue != bwm_pkg::CNT_W'(bwm_pkg::ENTRIES));
    assign finish     = (r_state == ST_DONE) && (!r_rsp_valid || o_rsp.ready);
    assign set_ok     = r_found || r_free_found;
    assign wr_idx     = r_found ? r_hit_idx : r_free_idx;

    assign ram_re    = (r_state == ST_SCAN) && issue_left;
    assign ram_we    = finish && (r_req.req_type == bwm_pkg::REQ_SET) && set_ok;
    assign ram_addr  = ram_we ? wr_idx : r_issue[bwm_pkg::IDX_W-1:0];

    always_comb begin
        ram_wdata.address     = r_req.address;
        ram_wdata.value       = r_req.data_value;
        ram_wdata.kinds       = {r_req.want_execute, r_req.want_write, r_req.want_read};
        ram_wdata.value_check = r_req.compare_value;
        ram_wdata.watch       = r_req.is_watch;
    end

    bwm_slot_ram #(
        .WIDTH ($bits(bwm_pkg::t_slot)),
        .DEPTH (bwm_pkg::ENTRIES)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (ram_re),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (rd_slot)
    );

    // compare stage on the slot read out last cycle
    assign slot_match = r_cmp_vld && r_valid[r_cmp_idx] && (rd_slot.address == r_req.address);
    assign slot_hit   = ((rd_slot.kinds & bwm_pkg::kind_mask(r_req.access_kind)) != 3'b000)
                        && (!rd_slot.value_check || (rd_slot.value == r_req.data_value));

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (req_acc) begin
                    if (i_req.payload.req_type == bwm_pkg::REQ_CHECK ||
                            i_req.payload.req_type == bwm_pkg::REQ_SET) begin
                        n_state = ST_SCAN;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_SCAN: begin
                if (!issue_left && !r_cmp_vld) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (finish) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_valid     <= '0;
            r_break_en  <= 1'b0;
            r_watch_en  <= 1'b0;
            r_issue     <= '0;
            r_cmp_vld   <= 1'b0;
            r_found     <= 1'b0;
            r_free_found <= 1'b0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    bwm_pkg::CFG_BREAK_EN: r_break_en <= i_cfg_wdata;
                    bwm_pkg::CFG_WATCH_EN: r_watch_en <= i_cfg_wdata;
                    default: ;
                endcase
            end

            if (req_acc) begin
                r_issue      <= '0;
                r_cmp_vld    <= 1'b0;
                r_found      <= 1'b0;
                r_free_found <= 1'b0;
                if (i_req.payload.req_type == bwm_pkg::REQ_CLEAR) begin
                    r_valid <= '0;
                end
            end else if (r_state == ST_SCAN) begin
                r_cmp_vld <= issue_left;
                if (issue_left) begin
                    r_issue <= r_issue + 1'b1;
                end
                if (slot_match && !r_found) begin
                    r_found <= 1'b1;
                end
                if (r_cmp_vld && !r_valid[r_cmp_idx] && !r_free_found) begin
                    r_free_found <= 1'b1;
                end
            end

            if (ram_we) begin
                r_valid[wr_idx] <= 1'b1;
            end

            if (finish) begin
                r_rsp_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (req_acc) begin
            r_req <= i_req.payload;
            r_brk <= 1'b0;
            r_wat <= 1'b0;
        end else if (r_state == ST_SCAN) begin
            r_cmp_idx <= r_issue[bwm_pkg::IDX_W-1:0];
            if (slot_match && !r_found) begin
                r_hit_idx <= r_cmp_idx;
                r_brk     <= slot_hit && !rd_slot.watch && r_break_en;
                r_wat     <= slot_hit && rd_slot.watch && r_watch_en;
            end
            if (r_cmp_vld && !r_valid[r_cmp_idx] && !r_free_found) begin
                r_free_idx <= r_cmp_idx;
            end
        end
        if (finish) begin
            r_rsp.break_hit <= (r_req.req_type == bwm_pkg::REQ_CHECK) && r_brk;
            r_rsp.watch_hit <= (r_req.req_type == bwm_pkg::REQ_CHECK) && r_wat;
            r_rsp.status    <= (r_req.req_type == bwm_pkg::REQ_SET) && !set_ok;
        end
    end

    assign i_req.ready   = (r_state == ST_IDLE);
    assign o_rsp.valid   = r_rsp_valid;
    assign o_rsp.payload = r_rsp;

    // one request in flight at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_acc |=> !i_req.ready)
        else $error("request accepted while another is in flight");

    // a matched slot is always a valid one
    a_found_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && r_found) |-> r_valid[r_hit_idx])
        else $error("match recorded on an invalid slot");

    // a result only appears out of the finish step
    a_rsp_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rsp.valid) |-> $past(r_state == ST_DONE))
        else $error("response raised outside the finish step");

    // a slot write never overlaps a scan read
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_we && ram_re))
        else $error("slot write collides with a scan read");

endmodule

@@ tb/sv/breakpoint_watchpoint_matcher_top_tb.sv @@
// testbench for the breakpoint / watchpoint match table: directed and random requests,
// responses checked field by field against a predictor held in a small scoreboard class
// depends on bwm_pkg, bwm_if and breakpoint_watchpoint_matcher_top

module breakpoint_watchpoint_matcher_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 4000;
    localparam int BLOCK_ITEMS = 150;
    localparam int POOL_ADDRS  = 20;
    localparam int POOL_VALUES = 4;

    // predictor of the match table plus the queue of responses still owed
    class match_table_scoreboard;
        logic           used [bwm_pkg::ENTRIES];
        bwm_pkg::t_slot slots [bwm_pkg::ENTRIES];
        logic           brk_en;
        logic           wat_en;
        bwm_pkg::t_rsp  pending_rsp [$];
        int             mismatch_cnt;

        function new();
            foreach (used[i]) used[i] = 1'b0;
            brk_en       = 1'b0;
            wat_en       = 1'b0;
            mismatch_cnt = 0;
        endfunction

        function void set_enables(logic b, logic w);
            brk_en = b;
            wat_en = w;
        endfunction

        function void note_request(bwm_pkg::t_req r);
            bwm_pkg::t_rsp rsp;
            int            hit_idx;
            int            free_idx;
            logic [2:0]    trig;
            rsp      = '0;
            hit_idx  = -1;
            free_idx = -1;
            // walk downward so the lowest matching / free slot wins
            for (int i = bwm_pkg::ENTRIES - 1; i >= 0; i--) begin
                if (used[i] && slots[i].address == r.address) hit_idx = i;
                if (!used[i]) free_idx = i;
            end
            case (r.req_type)
                bwm_pkg::REQ_CHECK: begin
                    case (r.access_kind)
                        bwm_pkg::KIND_READ:  trig = 3'b001;
                        bwm_pkg::KIND_WRITE: trig = 3'b010;
                        bwm_pkg::KIND_EXEC:  trig = 3'b100;
                        default:             trig = 3'b000;
                    endcase
                    if (hit_idx >= 0 && (slots[hit_idx].kinds & trig) != 3'b000 &&
                        (!slots[hit_idx].value_check ||
                         slots[hit_idx].value == r.data_value)) begin
                        // a watch entry never breaks, even with watchpoints off
                        if (slots[hit_idx].watch) rsp.watch_hit = wat_en;
                        else rsp.break_hit = brk_en;
                    end
                end
                bwm_pkg::REQ_SET: begin
                    if (hit_idx < 0) hit_idx = free_idx;
                    if (hit_idx < 0) begin
                        rsp.status = 1'b1;
                    end else begin
                        used[hit_idx]              = 1'b1;
                        slots[hit_idx].address     = r.address;
                        slots[hit_idx].value       = r.data_value;
                        slots[hit_idx].kinds       = {r.want_execute, r.want_write, r.want_read};
                        slots[hit_idx].value_check = r.compare_value;
                        slots[hit_idx].watch       = r.is_watch;
                    end
                end
                bwm_pkg::REQ_CLEAR: begin
                    foreach (used[i]) used[i] = 1'b0;
                end
                default: begin
                end
            endcase
            pending_rsp.push_back(rsp);
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            mismatch_cnt++;
        endtask

        task check_response(bwm_pkg::t_rsp got);
            bwm_pkg::t_rsp want;
            if (pending_rsp.size() == 0) begin
                report_mismatch($sformatf("response %b with nothing outstanding", got));
                return;
            end
            want = pending_rsp.pop_front();
            if (got.break_hit !== want.break_hit)
                report_mismatch($sformatf("break_hit %b, want %b", got.break_hit, want.break_hit));
            if (got.watch_hit !== want.watch_hit)
                report_mismatch($sformatf("watch_hit %b, want %b", got.watch_hit, want.watch_hit));
            if (got.status !== want.status)
                report_mismatch($sformatf("status %b, want %b", got.status, want.status));
        endtask

        task check_leftover();
            if (pending_rsp.size() != 0)
                report_mismatch($sformatf("%0d responses never arrived", pending_rsp.size()));
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;
    logic cfg_we;
    logic cfg_idx;
    logic cfg_wdata;

    bwm_req_if req_if ();
    bwm_rsp_if rsp_if ();

    match_table_scoreboard sb = new();

    int          send_idle_pct;
    int          rcv_idle_pct;
    int          stall_cnt;
    logic [31:0] addr_pool [POOL_ADDRS];
    logic [31:0] value_pool [POOL_VALUES];

    breakpoint_watchpoint_matcher_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_if),
        .o_rsp       (rsp_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n        = 1'b0;
        cfg_we         = 1'b0;
        cfg_idx        = bwm_pkg::CFG_BREAK_EN;
        cfg_wdata      = 1'b0;
        req_if.valid   = 1'b0;
        req_if.payload = '0;
        rsp_if.ready   = 1'b0;
        send_idle_pct  = 35;
        rcv_idle_pct   = 67;
        stall_cnt      = 0;
    end

    always @(posedge i_clk) begin
        rsp_if.ready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    // observe transactions on both channels
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (req_if.valid && req_if.ready) sb.note_request(req_if.payload);
            if (rsp_if.valid && rsp_if.ready) sb.check_response(rsp_if.payload);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            stall_cnt <= 0;
        end else if (stall_cnt >= STALL_LIMIT) begin
            $display("breakpoint_watchpoint_matcher_top_tb NOT OK");
            $finish;
        end else begin
            stall_cnt <= stall_cnt + 1;
        end
    end

    function automatic bwm_pkg::t_req build_req(logic [1:0] rq, logic [31:0] a,
                                                logic [31:0] d, logic [1:0] k,
                                                logic [4:0] flags);
        bwm_pkg::t_req r;
        r.req_type      = rq;
        r.address       = a;
        r.data_value    = d;
        r.access_kind   = k;
        r.want_read     = flags[4];
        r.want_write    = flags[3];
        r.want_execute  = flags[2];
        r.compare_value = flags[1];
        r.is_watch      = flags[0];
        return r;
    endfunction

    function automatic logic [31:0] pick_value();
        if ($urandom_range(3) != 0) return value_pool[$urandom_range(POOL_VALUES - 1)];
        return $urandom();
    endfunction

    // mostly sets and checks on a small address pool so entries get hit and the table fills
    function automatic bwm_pkg::t_req random_req();
        int         sel;
        logic [1:0] k;
        sel = $urandom_range(999);
        k   = ($urandom_range(9) == 0) ? 2'd3 : 2'($urandom_range(2));
        if (sel < 15)
            return build_req(bwm_pkg::REQ_CLEAR, $urandom(), $urandom(), 2'($urandom()),
                             5'($urandom()));
        if (sel < 30)
            return build_req(2'd3, $urandom(), $urandom(), 2'($urandom()), 5'($urandom()));
        if (sel < 330)
            return build_req(bwm_pkg::REQ_SET, addr_pool[$urandom_range(POOL_ADDRS - 1)],
                             pick_value(), 2'($urandom()), 5'($urandom()));
        if (sel < 880)
            return build_req(bwm_pkg::REQ_CHECK, addr_pool[$urandom_range(POOL_ADDRS - 1)],
                             pick_value(), k, 5'($urandom()));
        return build_req(bwm_pkg::REQ_CHECK, $urandom(), $urandom(), 2'($urandom()),
                         5'($urandom()));
    endfunction

    task automatic send_req(input bwm_pkg::t_req item);
        while ($urandom_range(99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid   <= 1'b1;
        req_if.payload <= item;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
    endtask

    task automatic wait_responses();
        req_if.valid <= 1'b0;
        // let the observer note the transaction accepted at this edge
        @(posedge i_clk);
        while (sb.pending_rsp.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_enables(input logic b, input logic w);
        cfg_we    <= 1'b1;
        cfg_idx   <= bwm_pkg::CFG_BREAK_EN;
        cfg_wdata <= b;
        @(posedge i_clk);
        cfg_idx   <= bwm_pkg::CFG_WATCH_EN;
        cfg_wdata <= w;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        sb.set_enables(b, w);
    endtask

    task automatic refresh_pools();
        addr_pool[0] = 32'h0000_0000;
        addr_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < POOL_ADDRS; i++) addr_pool[i] = $urandom();
        value_pool[0] = 32'h0000_0000;
        value_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < POOL_VALUES; i++) value_pool[i] = $urandom();
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // plain entry at the lowest address, compared watch entry at the highest
        set_enables(1'b1, 1'b1);
        send_req(build_req(bwm_pkg::REQ_SET, 32'h0000_0000, $urandom(), bwm_pkg::KIND_READ,
                           5'b11100));
        send_req(build_req(bwm_pkg::REQ_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, bwm_pkg::KIND_READ,
                           5'b01011));
        send_req(build_req(bwm_pkg::REQ_CHECK, 32'h0000_0000, $urandom(), bwm_pkg::KIND_READ,
                           5'b00000));
        send_req(build_req(bwm_pkg::REQ_CHECK, 32'h0000_0000, 32'h0, 2'd3, 5'b00000));
        send_req(build_req(bwm_pkg::REQ_CHECK, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                           bwm_pkg::KIND_WRITE, 5'b11111));
        send_req(build_req(bwm_pkg::REQ_CHECK, 32'hFFFF_FFFF, 32'h0000_0000,
                           bwm_pkg::KIND_WRITE, 5'b00000));
        send_req(build_req(2'd3, $urandom(), $urandom(), 2'($urandom()), 5'($urandom())));
        wait_responses();
        set_enables(1'b0, 1'b1);
        send_req(build_req(bwm_pkg::REQ_CHECK, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                           bwm_pkg::KIND_WRITE, 5'b00000));
        wait_responses();
        // watch entry with watchpoints off must stay silent
        set_enables(1'b1, 1'b0);
        send_req(build_req(bwm_pkg::REQ_CHECK, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                           bwm_pkg::KIND_WRITE, 5'b00000));
        wait_responses();
        set_enables(1'b0, 1'b0);
        send_req(build_req(bwm_pkg::REQ_CHECK, 32'h0000_0000, 32'h0, bwm_pkg::KIND_EXEC,
                           5'b00000));
        wait_responses();
        set_enables(1'b1, 1'b1);
        // entry with no trigger bits never hits
        send_req(build_req(bwm_pkg::REQ_SET, 32'h0000_0000, 32'h0, bwm_pkg::KIND_READ,
                           5'b00000));
        send_req(build_req(bwm_pkg::REQ_CHECK, 32'h0000_0000, 32'h0, bwm_pkg::KIND_READ,
                           5'b00000));
        for (int i = 1; i <= bwm_pkg::ENTRIES - 2; i++)
            send_req(build_req(bwm_pkg::REQ_SET, 32'h1000 * i, $urandom(), bwm_pkg::KIND_READ,
                               5'($urandom())));
        // table full: new address rejected, existing one still overwritten
        send_req(build_req(bwm_pkg::REQ_SET, 32'hDEAD_0000, 32'h0, bwm_pkg::KIND_READ,
                           5'b11100));
        send_req(build_req(bwm_pkg::REQ_SET, 32'h0000_0000, 32'h0, bwm_pkg::KIND_READ,
                           5'b11100));
        send_req(build_req(bwm_pkg::REQ_CHECK, 32'h0000_0000, 32'h0, bwm_pkg::KIND_EXEC,
                           5'b00000));
        send_req(build_req(bwm_pkg::REQ_CLEAR, 32'h0, 32'h0, bwm_pkg::KIND_READ, 5'b00000));
        send_req(build_req(bwm_pkg::REQ_CHECK, 32'h0000_0000, 32'h0, bwm_pkg::KIND_EXEC,
                           5'b00000));

        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 35 : (ph == 1) ? 67 : 0;
            rcv_idle_pct  = (ph == 0) ? 67 : (ph == 1) ? 35 : 0;
            refresh_pools();
            for (int blk = 0; blk < 4; blk++) begin
                wait_responses();
                set_enables(1'($urandom_range(1)), 1'($urandom_range(1)));
                for (int n = 0; n < BLOCK_ITEMS; n++) send_req(random_req());
            end
        end

        wait_responses();
        repeat (bwm_pkg::ENTRIES + 4) @(posedge i_clk);
        sb.check_leftover();
        if (sb.mismatch_cnt == 0) begin
            $display("breakpoint_watchpoint_matcher_top_tb OK");
        end else begin
            $display("breakpoint_watchpoint_matcher_top_tb NOT OK");
        end
        $finish;
    end

endmodule
